/* sv/isms_pkg.sv */
// ----------------------------------------------------------------------------
// isms_pkg
// shared types for the interval set merge insert unit
// ----------------------------------------------------------------------------
package isms_pkg;

   localparam int START_W = 63;
   localparam int LEN_W   = 63;
   localparam int END_W   = 64;
   localparam int COUNT_W = 5;

   typedef enum logic {
      ACT_INSERT = 1'b0,
      ACT_CLEAR  = 1'b1
   } isms_action_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_PLACE,
      ST_EMIT
   } isms_state_type;

   typedef struct packed {
      logic               used;
      logic [START_W-1:0] start;
      logic [END_W-1:0]   length;
   } isms_entry_type;

   typedef struct packed {
      logic shift;
      logic clr;
   } isms_cell_ctl_type;

endpackage

/* sv/isms_if.sv */
// ----------------------------------------------------------------------------
// isms request and response channels
// valid/ready channels carrying the insert or clear request and the table summary
// ----------------------------------------------------------------------------
interface isms_req_if;
   import isms_pkg::*;
   logic               valid;
   logic               ready;
   logic               action;
   logic [START_W-1:0] new_start;
   logic [LEN_W-1:0]   new_length;

   modport source(output valid, action, new_start, new_length, input ready);
   modport sink(input valid, action, new_start, new_length, output ready);
endinterface

interface isms_rsp_if;
   import isms_pkg::*;
   logic               valid;
   logic               ready;
   logic               dropped;
   logic [COUNT_W-1:0] entry_count;
   logic [END_W-1:0]   covered_total;
   logic [START_W-1:0] lowest_start;
   logic [END_W-1:0]   highest_end;
   logic               is_empty;

   modport source(output valid, dropped, entry_count, covered_total, lowest_start,
                  highest_end, is_empty, input ready);
   modport sink(input valid, dropped, entry_count, covered_total, lowest_start,
                highest_end, is_empty, output ready);
endinterface

/* sv/isms_cell.sv */
// ----------------------------------------------------------------------------
// isms_cell
// one table slot of the rotating range chain
// ----------------------------------------------------------------------------
module isms_cell import isms_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  isms_cell_ctl_type ctl,
   input  isms_entry_type    shift_in,
   input  logic              wr,
   input  isms_entry_type    wr_data,
   output isms_entry_type    entry
);

   logic               used_ff, used_in;
   logic [START_W-1:0] start_ff, start_in;
   logic [END_W-1:0]   length_ff, length_in;

   always_comb begin
      used_in   = used_ff;
      start_in  = start_ff;
      length_in = length_ff;
      if (ctl.clr) begin
         used_in = 1'b0;
      end else if (wr) begin
         used_in   = wr_data.used;
         start_in  = wr_data.start;
         length_in = wr_data.length;
      end else if (ctl.shift) begin
         used_in   = shift_in.used;
         start_in  = shift_in.start;
         length_in = shift_in.length;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         used_ff <= 1'b0;
      end else begin
         used_ff <= used_in;
      end
   end

   always_ff @(posedge clock) begin
      start_ff  <= start_in;
      length_ff <= length_in;
   end

   assign entry = '{used: used_ff, start: start_ff, length: length_ff};

endmodule

/* sv/interval_set_merge_insert_unit.sv */
// ----------------------------------------------------------------------------
// interval_set_merge_insert_unit
// coalescing table of disjoint byte ranges held in a rotating chain of cells
//
//   channel   dir  handshake       contents
//   req_ch    in   valid/ready     action, new_start, new_length
//   rsp_ch    out  valid/ready     dropped, count, total, lowest, highest, empty
//
// an insert rotates the chain once past the compare head, then places the
// merged range if a slot came free, then loads the response
// a clear empties the table when it is accepted, then loads the response
// reset is synchronous and empties the table
// a pending response holds the final load, and with it the next request
// ----------------------------------------------------------------------------
module interval_set_merge_insert_unit import isms_pkg::*; #(
   parameter int TABLE_ENTRIES = 16
) (
   input logic        clock,
   input logic        reset,
   isms_req_if.sink   req_ch,
   isms_rsp_if.source rsp_ch
);

   localparam int IDX_W = $clog2(TABLE_ENTRIES);
   localparam int CNT_W = $clog2(TABLE_ENTRIES + 1);

   isms_state_type state_ff, state_in;

   logic [START_W-1:0] xs_ff, lo_ff, kmin_ff;
   logic [END_W-1:0]   xe_ff, hi_ff, kmax_ff, ksum_ff, mlen_ff;
   logic [IDX_W-1:0]   step_ff, hole_idx_ff;
   logic [CNT_W-1:0]   kcount_ff;
   logic               hole_ff, kany_ff, insert_ff;

   logic               rsp_valid_ff;
   logic               dropped_ff, empty_ff;
   logic [COUNT_W-1:0] count_ff;
   logic [END_W-1:0]   total_ff, highest_ff;
   logic [START_W-1:0] lowest_ff;

   logic req_ready, accept, last_step, do_shift, do_place, do_load, clr;

   isms_entry_type    cell_q [TABLE_ENTRIES];
   isms_entry_type    recycle, head, place_data;
   isms_cell_ctl_type cell_ctl;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               state_in = (req_ch.action == ACT_CLEAR) ? ST_EMIT : ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (last_step) begin
               state_in = ST_PLACE;
            end
         end
         ST_PLACE: state_in = ST_EMIT;
         ST_EMIT: begin
            if (!rsp_valid_ff || rsp_ch.ready) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // control outputs
   always_comb begin
      req_ready = 1'b0;
      do_shift  = 1'b0;
      do_place  = 1'b0;
      do_load   = 1'b0;
      case (state_ff)
         ST_IDLE:  req_ready = 1'b1;
         ST_SCAN:  do_shift  = 1'b1;
         ST_PLACE: do_place  = hole_ff;
         ST_EMIT:  do_load   = !rsp_valid_ff || rsp_ch.ready;
         default:  req_ready = 1'b0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign accept    = req_ch.valid && req_ready;
   assign clr       = accept && (req_ch.action == ACT_CLEAR);
   assign last_step = (step_ff == IDX_W'(TABLE_ENTRIES - 1));
   assign req_ch.ready = req_ready;

   // compare head
   logic [END_W-1:0] h_end;
   logic             h_join, h_keep;
   logic [END_W:0]   ksum_add;

   assign head     = cell_q[0];
   assign h_end    = {1'b0, head.start} + head.length;
   assign h_join   = head.used && ({1'b0, head.start} <= xe_ff) && (h_end >= {1'b0, xs_ff});
   assign h_keep   = head.used && !h_join;
   assign ksum_add = {1'b0, ksum_ff} + {1'b0, head.length};
   assign recycle  = '{used: h_keep, start: head.start, length: head.length};

   // cell chain
   assign cell_ctl   = '{shift: do_shift, clr: clr};
   assign place_data = '{used: 1'b1, start: lo_ff, length: hi_ff - {1'b0, lo_ff}};

   for (genvar i = 0; i < TABLE_ENTRIES; i++) begin : g_cell
      isms_cell u_cell (
         .clock    (clock),
         .reset    (reset),
         .ctl      (cell_ctl),
         .shift_in ((i == TABLE_ENTRIES - 1) ? recycle : cell_q[(i + 1) % TABLE_ENTRIES]),
         .wr       (do_place && (hole_idx_ff == IDX_W'(i))),
         .wr_data  (place_data),
         .entry    (cell_q[i])
      );
   end

   // scan accumulators
   always_ff @(posedge clock) begin
      if (accept) begin
         xs_ff     <= req_ch.new_start;
         xe_ff     <= {1'b0, req_ch.new_start} + {1'b0, req_ch.new_length};
         lo_ff     <= req_ch.new_start;
         hi_ff     <= {1'b0, req_ch.new_start} + {1'b0, req_ch.new_length};
         step_ff   <= '0;
         hole_ff   <= 1'b0;
         kcount_ff <= '0;
         ksum_ff   <= '0;
         kany_ff   <= 1'b0;
         insert_ff <= (req_ch.action == ACT_INSERT);
      end else if (do_shift) begin
         step_ff <= step_ff + 1'b1;
         if (h_join) begin
            if (head.start < lo_ff) begin
               lo_ff <= head.start;
            end
            if (h_end > hi_ff) begin
               hi_ff <= h_end;
            end
         end
         if (!h_keep && !hole_ff) begin
            hole_ff     <= 1'b1;
            hole_idx_ff <= step_ff;
         end
         if (h_keep) begin
            kcount_ff <= kcount_ff + 1'b1;
            ksum_ff   <= ksum_add[END_W] ? '1 : ksum_add[END_W-1:0];
            kany_ff   <= 1'b1;
            if (!kany_ff || head.start < kmin_ff) begin
               kmin_ff <= head.start;
            end
            if (!kany_ff || h_end > kmax_ff) begin
               kmax_ff <= h_end;
            end
         end
      end else if (state_ff == ST_PLACE) begin
         mlen_ff <= place_data.length;
      end
   end

   // response register
   logic             placed;
   logic [END_W:0]   tsum;
   logic [CNT_W-1:0] fcount;

   assign placed = insert_ff && hole_ff;
   assign tsum   = {1'b0, ksum_ff} + {1'b0, mlen_ff};
   assign fcount = placed ? kcount_ff + 1'b1 : kcount_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (do_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ch.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (do_load) begin
         dropped_ff <= insert_ff && !hole_ff;
         count_ff   <= COUNT_W'(fcount);
         empty_ff   <= !placed && !kany_ff;
         if (placed) begin
            total_ff   <= tsum[END_W] ? '1 : tsum[END_W-1:0];
            lowest_ff  <= (kany_ff && kmin_ff < lo_ff) ? kmin_ff : lo_ff;
            highest_ff <= (kany_ff && kmax_ff > hi_ff) ? kmax_ff : hi_ff;
         end else begin
            total_ff   <= kany_ff ? ksum_ff : '0;
            lowest_ff  <= kany_ff ? kmin_ff : '0;
            highest_ff <= kany_ff ? kmax_ff : '0;
         end
      end
   end

   assign rsp_ch.valid         = rsp_valid_ff;
   assign rsp_ch.dropped       = dropped_ff;
   assign rsp_ch.entry_count   = count_ff;
   assign rsp_ch.covered_total = total_ff;
   assign rsp_ch.lowest_start  = lowest_ff;
   assign rsp_ch.highest_end   = highest_ff;
   assign rsp_ch.is_empty      = empty_ff;

endmodule

/* sv/isms_checker.sv */
// ----------------------------------------------------------------------------
// isms_checker
// port level checks for the interval set merge insert unit
// ----------------------------------------------------------------------------
module isms_checker import isms_pkg::*; #(
   parameter int TABLE_ENTRIES = 16
) (
   input logic               clock,
   input logic               reset,
   input logic               rsp_valid,
   input logic               rsp_ready,
   input logic               dropped,
   input logic [COUNT_W-1:0] entry_count,
   input logic [END_W-1:0]   covered_total,
   input logic [START_W-1:0] lowest_start,
   input logic [END_W-1:0]   highest_end,
   input logic               is_empty
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("response dropped while stalled");

   a_empty_count: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (is_empty == (entry_count == '0)) || (entry_count == '0 && !is_empty))
      else $error("empty flag disagrees with count");

   a_empty_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && is_empty |-> lowest_start == '0 && highest_end == '0 && covered_total == '0)
      else $error("empty table reports ranges");

   a_drop_full: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && dropped |-> entry_count == COUNT_W'(TABLE_ENTRIES))
      else $error("drop while table not full");

   a_order: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !is_empty |-> highest_end >= {1'b0, lowest_start})
      else $error("highest end below lowest start");

endmodule

bind interval_set_merge_insert_unit isms_checker #(.TABLE_ENTRIES(TABLE_ENTRIES)) u_isms_checker (
   .clock         (clock),
   .reset         (reset),
   .rsp_valid     (rsp_ch.valid),
   .rsp_ready     (rsp_ch.ready),
   .dropped       (rsp_ch.dropped),
   .entry_count   (rsp_ch.entry_count),
   .covered_total (rsp_ch.covered_total),
   .lowest_start  (rsp_ch.lowest_start),
   .highest_end   (rsp_ch.highest_end),
   .is_empty      (rsp_ch.is_empty)
);
